@@ rtl/core/swma_pkg.sv @@
// Shared types and constants for the three-channel sensor moving average.
// No dependencies.
`timescale 1ns / 1ps

package swma_pkg;

  localparam int unsigned ChannelCount = 3;
  localparam int unsigned ChannelW     = 2;
  localparam int unsigned SampleW      = 24;

  localparam logic [ChannelW-1:0] ChPressure    = 2'd0;
  localparam logic [ChannelW-1:0] ChTemperature = 2'd1;
  localparam logic [ChannelW-1:0] ChAltitude    = 2'd2;
  localparam logic [ChannelW-1:0] ChUnused      = 2'd3;

  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic [SampleW-1:0]  raw_value;
  } swma_in_t;

  typedef struct packed {
    logic [ChannelW-1:0]        channel_out;
    logic signed [SampleW-1:0]  sample_value;
    logic signed [SampleW-1:0]  average_value;
  } swma_out_t;

endpackage

@@ rtl/core/sensor_word_moving_average.sv @@
// Three-channel boxcar moving average over signed 24-bit sensor words.
// A result is registered in stage 1, then in the output register, after its input transfer.
// Throughput: one transfer per cycle unless the output stalls; the window RAM is read
// and written at the same slot in the accept cycle, the running sum as stage 1 advances.
// Reset (async, active low) clears control, running sums and the per-slot
// valid bits, so every window reads as zero; no clearing pass is needed.
`timescale 1ns / 1ps

module sensor_word_moving_average
  import swma_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = 8  // power of two, 2..64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  swma_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output swma_out_t out_data_o
);

  localparam int unsigned PtrW  = $clog2(WINDOW_LENGTH);
  localparam int unsigned Depth = ChannelCount * WINDOW_LENGTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SumW  = SampleW + PtrW;

  // handshake
  logic in_acc, in_live, out_adv, s1_adv;

  // write pointers, one per channel
  logic [PtrW-1:0]  ptr_q [ChannelCount];
  logic [PtrW-1:0]  wr_ptr;
  logic [AddrW-1:0] wr_addr;

  // window RAM and slot valid bits
  logic [SampleW-1:0] mem_q [Depth];
  logic [Depth-1:0]   vld_q;

  // stage 1
  logic                      s1_valid_q;
  logic [ChannelW-1:0]       s1_ch_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic [SampleW-1:0]        old_q;
  logic                      old_vld_q;

  // running sums
  logic signed [SumW-1:0]    sum_q [ChannelCount];
  logic signed [SumW-1:0]    sum_d;
  logic signed [SampleW-1:0] old_sample;

  // output register
  logic      out_valid_q;
  swma_out_t out_q;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_live    = in_acc && (in_data_i.channel != ChUnused);

  assign wr_ptr  = (in_data_i.channel == ChUnused) ? '0 : ptr_q[in_data_i.channel];
  assign wr_addr = AddrW'({in_data_i.channel, wr_ptr});

  assign old_sample = old_vld_q ? signed'(old_q) : '0;
  assign sum_d      = sum_q[s1_ch_q] - SumW'(old_sample) + SumW'(s1_sample_q);

  // slot holds the oldest sample of the channel; read before overwrite
  always_ff @(posedge clk_i) begin
    if (in_live) begin
      old_q            <= mem_q[wr_addr];
      mem_q[wr_addr]   <= in_data_i.raw_value;
      s1_ch_q          <= in_data_i.channel;
      s1_sample_q      <= signed'(in_data_i.raw_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      old_vld_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      for (int c = 0; c < ChannelCount; c++) begin
        ptr_q[c] <= '0;
      end
    end else begin
      if (in_acc) begin
        s1_valid_q <= in_live;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (in_live) begin
        old_vld_q                <= vld_q[wr_addr];
        vld_q[wr_addr]           <= 1'b1;
        ptr_q[in_data_i.channel] <= wr_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int c = 0; c < ChannelCount; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        sum_q[s1_ch_q] <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.channel_out   <= s1_ch_q;
      out_q.sample_value  <= s1_sample_q;
      out_q.average_value <= signed'(sum_d[PtrW +: SampleW]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_unused_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.channel == ChUnused) |=> !s1_valid_q)
    else $error("unused channel entered the pipeline");

  a_live_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_live |=> s1_valid_q && (s1_ch_q == $past(in_data_i.channel)))
    else $error("accepted item missing from stage 1");

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(old_q) && $stable(s1_sample_q))
    else $error("stalled stage 1 changed");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without transfer");
`endif

endmodule

@@ bench/tb_sensor_word_moving_average.sv @@
// Self-checking bench for sensor_word_moving_average: a directed table, then random bursts.
// A local boxcar predictor checks every result but typed rows, which use table values. Random idles on both sides.
// Depends on swma_pkg and the sensor_word_moving_average RTL.
`timescale 1ns / 1ps

module tb_sensor_word_moving_average;
  import swma_pkg::*;

  localparam int WinLen      = 8;
  localparam int WinShift    = $clog2(WinLen);
  localparam int SumW        = SampleW + WinShift;
  localparam int RandomItems = 1850;
  localparam int CycleLimit  = 1_000_000;
  localparam int TailCycles  = 8;

  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic [SampleW-1:0]  raw;
    int                  reps;
    bit                  typed;
    int                  exp_sample;
    int                  exp_avg;
  } stim_row_t;

  // typed rows: the first samples of a window, or a window full of one value
  localparam int NumDirected = 13;
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{ChPressure,    24'h7FFFFF, 1, 1'b1,  8388607,  1048575},
    '{ChTemperature, 24'h800000, 1, 1'b1, -8388608, -1048576},
    '{ChAltitude,    24'hFFFFFF, 1, 1'b1,       -1,       -1},
    '{ChUnused,      24'h123456, 1, 1'b0,        0,        0},  // ignored, no transfer out
    '{ChUnused,      24'hFFFFFF, 1, 1'b0,        0,        0},
    '{ChAltitude,    24'h000000, 1, 1'b1,        0,       -1},
    '{ChPressure,    24'h7FFFFF, 6, 1'b0,        0,        0},
    '{ChPressure,    24'h7FFFFF, 1, 1'b1,  8388607,  8388607},
    '{ChTemperature, 24'h800000, 6, 1'b0,        0,        0},
    '{ChTemperature, 24'h800000, 1, 1'b1, -8388608, -8388608},
    '{ChAltitude,    24'h555555, 1, 1'b0,        0,        0},
    '{ChAltitude,    24'hAAAAAA, 1, 1'b0,        0,        0},
    '{ChPressure,    24'h000001, 1, 1'b0,        0,        0}
  };

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  swma_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  swma_out_t out_data;

  logic signed [SampleW-1:0] window_q [ChannelCount][WinLen];
  logic signed [SumW-1:0]    sum_q    [ChannelCount];
  swma_out_t                 expected_averages [$];

  int failures    = 0;
  int cycle_count = 0;
  int send_mode   = 1;
  int drain_mode  = 1;
  int drain_left  = 100;
  int stall_left  = 0;

  always #5 clk_i = ~clk_i;

  sensor_word_moving_average #(
    .WINDOW_LENGTH(WinLen)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // mode 0: no idles, 1: light, 2: heavy
  function automatic int draw_idle(input int mode);
    int r;
    r = int'($urandom_range(0, 99));
    if (mode == 0) return 0;
    if (r < (mode == 1 ? 70 : 30)) return 0;
    if (r < 94) return int'($urandom_range(1, 4));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic bit advance_window(input swma_in_t item, output swma_out_t res);
    logic signed [SampleW-1:0] sample;
    logic signed [SumW-1:0]    avg;
    int                        c;
    res = '0;
    if (item.channel == ChUnused) return 1'b0;
    c      = int'(item.channel);
    sample = $signed(item.raw_value);
    sum_q[c] = sum_q[c] - SumW'(window_q[c][WinLen-1]) + SumW'(sample);
    for (int i = WinLen - 1; i > 0; i--) window_q[c][i] = window_q[c][i-1];
    window_q[c][0] = sample;
    avg = sum_q[c] >>> WinShift;
    res.channel_out   = item.channel;
    res.sample_value  = sample;
    res.average_value = avg[SampleW-1:0];
    return 1'b1;
  endfunction

  task automatic push_reading(input swma_in_t item, input bit typed,
                              input int exp_sample, input int exp_avg);
    int        gap;
    swma_out_t res;
    gap = draw_idle(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    if (advance_window(item, res)) begin
      if (typed) begin
        res.sample_value  = SampleW'(exp_sample);
        res.average_value = SampleW'(exp_avg);
      end
      expected_averages.push_back(res);
    end
  endtask

  task automatic check_average(input swma_out_t got);
    swma_out_t want;
    if (expected_averages.size() == 0) begin
      $error("unexpected transfer out: channel_out %0d", got.channel_out);
      failures++;
      return;
    end
    want = expected_averages.pop_front();
    if (got.channel_out !== want.channel_out) begin
      $error("channel_out: expected %0d, actual %0d", want.channel_out, got.channel_out);
      failures++;
    end
    if (got.sample_value !== want.sample_value) begin
      $error("sample_value: expected %0d, actual %0d", want.sample_value, got.sample_value);
      failures++;
    end
    if (got.average_value !== want.average_value) begin
      $error("average_value: expected %0d, actual %0d", want.average_value,
             got.average_value);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) check_average(out_data);
      if (--drain_left <= 0) begin
        drain_mode = int'($urandom_range(0, 2));
        drain_left = int'($urandom_range(50, 300));
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = draw_idle(drain_mode);
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** sensor_word_moving_average: FAILED **");
      $finish;
    end
  end

  initial begin
    swma_in_t            item;
    int                  random_results;
    int                  burst_kind;
    int                  burst_len;
    logic [ChannelW-1:0] ch;
    logic [SampleW-1:0]  level;
    int                  small_val;

    random_results = 0;
    foreach (sum_q[c]) begin
      sum_q[c] = '0;
      for (int i = 0; i < WinLen; i++) window_q[c][i] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      for (int k = 0; k < DirectedRows[r].reps; k++) begin
        item.channel   = DirectedRows[r].channel;
        item.raw_value = DirectedRows[r].raw;
        push_reading(item, DirectedRows[r].typed, DirectedRows[r].exp_sample,
                     DirectedRows[r].exp_avg);
      end
    end

    while (random_results < RandomItems) begin
      burst_kind = int'($urandom_range(0, 9));
      burst_len  = int'($urandom_range(1, 16));
      send_mode  = int'($urandom_range(0, 2));
      ch         = ChannelW'($urandom_range(0, ChannelCount - 1));
      level      = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      if (burst_kind == 4 || burst_kind == 5) burst_len = int'($urandom_range(8, 12));
      for (int k = 0; k < burst_len; k++) begin
        item.channel = ch;
        if (burst_kind < 4) begin
          item.channel   = ChannelW'($urandom_range(0, ChannelCount - 1));
          item.raw_value = SampleW'($urandom);
        end else if (burst_kind < 6) begin
          item.raw_value = level;
        end else if (burst_kind < 8) begin
          small_val      = int'($urandom_range(0, 16)) - 8;
          item.raw_value = small_val[SampleW-1:0];
        end else if (burst_kind == 8) begin
          item.channel   = ChUnused;
          item.raw_value = SampleW'($urandom);
        end else begin
          item.raw_value = k[0] ? 24'h7FFFFF : 24'h800000;
        end
        push_reading(item, 1'b0, 0, 0);
        random_results++;
      end
    end
    in_valid <= 1'b0;

    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("** sensor_word_moving_average: PASSED **");
    end else begin
      $display("** sensor_word_moving_average: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/swma_pkg.sv
rtl/core/sensor_word_moving_average.sv
bench/tb_sensor_word_moving_average.sv
